@@ rtl/gji_pkg.sv @@
// ----------------------------------------------------------------------------
// gji_pkg
// Shared types and codes for the Gauss-Jordan inverse block.
// ----------------------------------------------------------------------------
package gji_pkg;

  // sequencer states
  typedef enum logic [4:0] {
    S_LOAD,
    S_IDENT,
    S_PIV_RD,
    S_PIV_WAIT,
    S_PIV_SAT,
    S_DIV_RD,
    S_DIV_WAIT,
    S_DIV_RUN,
    S_DIV_WR,
    S_ROW,
    S_F_RD,
    S_F_WAIT,
    S_EL_RD,
    S_EL_WAIT,
    S_EL_WR,
    S_OUT_RD,
    S_OUT_WAIT,
    S_OUT_HOLD,
    S_SING
  } gji_state_e;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_SING = 2'd1,
    STAT_SAT  = 2'd2
  } gji_status_e;

  // saturated 32-bit value with its overflow flag
  typedef struct packed {
    logic signed [31:0] val;
    logic               ovf;
  } fx_res_t;

  localparam int unsigned TDATA_IN_W  = 32;
  localparam int unsigned TDATA_OUT_W = 72;

endpackage

@@ rtl/gji_ram.sv @@
// ----------------------------------------------------------------------------
// gji_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gji_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/gji_div.sv @@
// ----------------------------------------------------------------------------
// gji_div
// Iterative signed fixed-point divider: (num << FRAC_BITS) / den, truncated
// toward zero and saturated to 32 bits. One quotient bit per cycle.
// ----------------------------------------------------------------------------
module gji_div #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic signed [31:0]  num_i,
  input  logic signed [31:0]  den_i,
  output logic                done_o,
  output gji_pkg::fx_res_t    res_o
);
  import gji_pkg::*;

  localparam int unsigned NW  = 32 + FRAC_BITS;
  localparam int unsigned CW  = $clog2(NW + 1);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [NW-1:0] dvd_q, dvd_d;
  logic [31:0]   rem_q, rem_d;
  logic [31:0]   den_q, den_d;
  logic          neg_q, neg_d;

  logic [32:0]   rem_sh;
  logic          qbit;
  logic [31:0]   num_mag;

  always_comb begin
    num_mag = num_i[31] ? 32'(-num_i) : 32'(num_i);
    rem_sh  = {rem_q, dvd_q[NW-1]};
    qbit    = (rem_sh >= {1'b0, den_q});
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    dvd_d   = dvd_q;
    rem_d   = rem_q;
    den_d   = den_q;
    neg_d   = neg_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = {num_mag, FRAC_BITS'(0)};
      rem_d  = '0;
      den_d  = den_i[31] ? 32'(-den_i) : 32'(den_i);
      neg_d  = num_i[31] ^ den_i[31];
    end else if (busy_q) begin
      rem_d = qbit ? 32'(rem_sh - {1'b0, den_q}) : rem_sh[31:0];
      dvd_d = {dvd_q[NW-2:0], qbit};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(NW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  // saturate the magnitude with its sign
  always_comb begin
    res_o.ovf = 1'b0;
    if (neg_q) begin
      if ((dvd_q[NW-1:32] != '0) || (dvd_q[31] && (dvd_q[30:0] != '0))) begin
        res_o.val = 32'sh8000_0000;
        res_o.ovf = 1'b1;
      end else begin
        res_o.val = 32'(-dvd_q[31:0]);
      end
    end else begin
      if (dvd_q[NW-1:31] != '0) begin
        res_o.val = 32'sh7FFF_FFFF;
        res_o.ovf = 1'b1;
      end else begin
        res_o.val = 32'(dvd_q[31:0]);
      end
    end
  end

  assign done_o = done_q;

endmodule

@@ rtl/gauss_jordan_matrix_inverse.sv @@
// ----------------------------------------------------------------------------
// gauss_jordan_matrix_inverse
// Fixed-point matrix inverse and determinant by Gauss-Jordan elimination.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_we_i/cfg_wdata_i set the matrix size n (0 acts as 1, values above
//   MAX_DIM act as MAX_DIM); a write drops any partial load.
//   The slave stream takes n*n signed Q16.16 elements row-major, one per
//   cycle while loading. The master stream then returns the n*n inverse
//   elements row-major with the determinant and status in every request,
//   tlast on the final one. A zero pivot gives a single request with
//   status singular, zero data and tlast.
//   All work sits in one augmented-matrix RAM (n rows of 2n words) that is
//   read, updated and written back one word at a time.
// Speed is set by the one-word-per-cycle RAM port and the bit-serial divider.
// Input is not taken while a run is being worked out or returned. A stalled
// receiver holds the current result; reset returns to loading with size 4.
// ----------------------------------------------------------------------------
module gauss_jordan_matrix_inverse #(
  parameter int unsigned MAX_DIM   = 8,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [3:0]                           cfg_wdata_i,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // [31:0] element
  input  logic [gji_pkg::TDATA_IN_W-1:0]       s_axis_tdata_i,
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  // [31:0] inverse_element, [63:32] determinant, [65:64] status, rest zero
  output logic [gji_pkg::TDATA_OUT_W-1:0]      m_axis_tdata_o,
  output logic                                 m_axis_tlast_o
);
  import gji_pkg::*;

  localparam int unsigned STRIDE = 2 * MAX_DIM;
  localparam int unsigned DEPTH  = MAX_DIM * STRIDE;
  localparam int unsigned AW     = $clog2(DEPTH);
  localparam int unsigned IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int unsigned COL_W  = $clog2(STRIDE);
  localparam int unsigned DIM_W  = $clog2(MAX_DIM + 1);
  localparam logic signed [31:0] ONE_FX = 32'(64'd1 << FRAC_BITS);
  localparam logic signed [63:0] MAX_V  = 64'sd2147483647;
  localparam logic signed [63:0] MIN_V  = -64'sd2147483648;

  function automatic logic [AW-1:0] addr_of(input logic [IDX_W-1:0] row,
                                            input logic [COL_W-1:0] col);
    addr_of = AW'(AW'(row) * AW'(STRIDE) + AW'(col));
  endfunction

  function automatic fx_res_t sat32(input logic signed [63:0] v);
    fx_res_t r;
    r.ovf = 1'b1;
    if (v > MAX_V) begin
      r.val = 32'sh7FFF_FFFF;
    end else if (v < MIN_V) begin
      r.val = 32'sh8000_0000;
    end else begin
      r.val = v[31:0];
      r.ovf = 1'b0;
    end
    return r;
  endfunction

  gji_state_e state_q, state_d;

  logic [3:0]              size_q;
  logic [IDX_W-1:0]        r_q, c_q, i_q, j_q;
  logic [COL_W-1:0]        k_q;
  logic signed [31:0]      pp_q, piv_q, f_q, old_q, out_elem_q;
  logic                    ovf_q, out_last_q;
  logic signed [63:0]      prod_q;
  logic signed [31:0]      prow_q [STRIDE];

  logic [DIM_W-1:0]        n_eff;
  logic [IDX_W-1:0]        n_m1;
  logic [COL_W-1:0]        n2_m1;
  logic [COL_W-1:0]        n_col;
  logic                    rc_last, row_last, piv_last, k_last;
  logic                    in_acc, out_acc;

  logic                    ram_we;
  logic [AW-1:0]           ram_waddr, ram_raddr;
  logic [31:0]             ram_wdata, ram_rdata;
  logic signed [31:0]      mul_a, mul_b;
  logic                    div_start, div_done;
  fx_res_t                 div_res, pp_sat, el_sat;

  always_comb begin
    if (size_q == 4'd0) begin
      n_eff = DIM_W'(1);
    end else if (int'(size_q) > int'(MAX_DIM)) begin
      n_eff = DIM_W'(MAX_DIM);
    end else begin
      n_eff = DIM_W'(size_q);
    end
    n_m1     = IDX_W'(n_eff - 1'b1);
    n_col    = COL_W'(n_eff);
    n2_m1    = COL_W'({n_eff, 1'b0} - 1'b1);
    rc_last  = (r_q == n_m1) && (c_q == n_m1);
    row_last = (j_q == n_m1);
    piv_last = (i_q == n_m1);
    k_last   = (k_q == n2_m1);
    in_acc   = s_axis_tvalid_i && s_axis_tready_o;
    out_acc  = m_axis_tvalid_o && m_axis_tready_i;
    pp_sat   = sat32(prod_q >>> FRAC_BITS);
    el_sat   = sat32(64'(old_q) - (prod_q >>> FRAC_BITS));
  end

  gji_ram #(
    .WIDTH(32),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  gji_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  ($signed(ram_rdata)),
    .den_i  (piv_q),
    .done_o (div_done),
    .res_o  (div_res)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_LOAD:     if (in_acc && rc_last) state_d = S_IDENT;
      S_IDENT:    if (rc_last) state_d = S_PIV_RD;
      S_PIV_RD:   state_d = S_PIV_WAIT;
      S_PIV_WAIT: state_d = (ram_rdata == '0) ? S_SING : S_PIV_SAT;
      S_PIV_SAT:  state_d = S_DIV_RD;
      S_DIV_RD:   state_d = S_DIV_WAIT;
      S_DIV_WAIT: state_d = S_DIV_RUN;
      S_DIV_RUN:  if (div_done) state_d = S_DIV_WR;
      S_DIV_WR:   state_d = k_last ? S_ROW : S_DIV_RD;
      S_ROW: begin
        if (j_q != i_q) begin
          state_d = S_F_RD;
        end else if (row_last) begin
          state_d = piv_last ? S_OUT_RD : S_PIV_RD;
        end
      end
      S_F_RD:     state_d = S_F_WAIT;
      S_F_WAIT:   state_d = S_EL_RD;
      S_EL_RD:    state_d = S_EL_WAIT;
      S_EL_WAIT:  state_d = S_EL_WR;
      S_EL_WR: begin
        if (!k_last) begin
          state_d = S_EL_RD;
        end else if (!row_last) begin
          state_d = S_ROW;
        end else begin
          state_d = piv_last ? S_OUT_RD : S_PIV_RD;
        end
      end
      S_OUT_RD:   state_d = S_OUT_WAIT;
      S_OUT_WAIT: state_d = S_OUT_HOLD;
      S_OUT_HOLD: if (out_acc) state_d = out_last_q ? S_LOAD : S_OUT_RD;
      S_SING:     if (out_acc) state_d = S_LOAD;
      default:    state_d = S_LOAD;
    endcase
    if (cfg_we_i) begin
      state_d = S_LOAD;
    end
  end

  // outputs and memory port
  always_comb begin
    s_axis_tready_o = 1'b0;
    m_axis_tvalid_o = 1'b0;
    ram_we          = 1'b0;
    ram_waddr       = addr_of(r_q, COL_W'(c_q));
    ram_wdata       = s_axis_tdata_i[31:0];
    ram_raddr       = addr_of(i_q, COL_W'(i_q));
    div_start       = 1'b0;
    mul_a           = f_q;
    mul_b           = prow_q[k_q];
    unique case (state_q)
      S_LOAD: begin
        s_axis_tready_o = 1'b1;
        ram_we          = in_acc;
      end
      S_IDENT: begin
        ram_we    = 1'b1;
        ram_waddr = addr_of(r_q, n_col + COL_W'(c_q));
        ram_wdata = (r_q == c_q) ? ONE_FX : '0;
      end
      S_PIV_WAIT: begin
        mul_a = pp_q;
        mul_b = $signed(ram_rdata);
      end
      S_DIV_RD:   ram_raddr = addr_of(i_q, k_q);
      S_DIV_WAIT: div_start = 1'b1;
      S_DIV_WR: begin
        ram_we    = 1'b1;
        ram_waddr = addr_of(i_q, k_q);
        ram_wdata = div_res.val;
      end
      S_F_RD:     ram_raddr = addr_of(j_q, COL_W'(i_q));
      S_EL_RD:    ram_raddr = addr_of(j_q, k_q);
      S_EL_WR: begin
        ram_we    = 1'b1;
        ram_waddr = addr_of(j_q, k_q);
        ram_wdata = el_sat.val;
      end
      S_OUT_RD:   ram_raddr = addr_of(r_q, n_col + COL_W'(c_q));
      S_OUT_HOLD: m_axis_tvalid_o = 1'b1;
      S_SING:     m_axis_tvalid_o = 1'b1;
      default: begin
      end
    endcase
  end

  always_comb begin
    if (state_q == S_SING) begin
      m_axis_tdata_o = {6'd0, STAT_SING, 32'd0, 32'd0};
      m_axis_tlast_o = 1'b1;
    end else begin
      m_axis_tdata_o = {6'd0, (ovf_q ? STAT_SAT : STAT_OK), pp_q, out_elem_q};
      m_axis_tlast_o = out_last_q;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_LOAD;
      size_q     <= 4'd4;
      r_q        <= '0;
      c_q        <= '0;
      i_q        <= '0;
      j_q        <= '0;
      k_q        <= '0;
      pp_q       <= ONE_FX;
      ovf_q      <= 1'b0;
      out_last_q <= 1'b0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        S_LOAD, S_IDENT: begin
          if ((state_q == S_IDENT) || in_acc) begin
            if (rc_last) begin
              r_q <= '0;
              c_q <= '0;
              i_q <= '0;
            end else if (c_q == n_m1) begin
              c_q <= '0;
              r_q <= r_q + 1'b1;
            end else begin
              c_q <= c_q + 1'b1;
            end
          end
        end
        S_PIV_SAT: begin
          pp_q  <= pp_sat.val;
          ovf_q <= ovf_q | pp_sat.ovf;
          k_q   <= '0;
        end
        S_DIV_WR: begin
          ovf_q <= ovf_q | div_res.ovf;
          if (k_last) begin
            k_q <= '0;
            j_q <= '0;
          end else begin
            k_q <= k_q + 1'b1;
          end
        end
        S_ROW: begin
          if (j_q == i_q) begin
            if (!row_last) begin
              j_q <= j_q + 1'b1;
            end else if (piv_last) begin
              r_q <= '0;
              c_q <= '0;
            end else begin
              i_q <= i_q + 1'b1;
            end
          end
        end
        S_F_WAIT: k_q <= '0;
        S_EL_WR: begin
          ovf_q <= ovf_q | el_sat.ovf;
          if (k_last) begin
            k_q <= '0;
            if (!row_last) begin
              j_q <= j_q + 1'b1;
            end else if (piv_last) begin
              r_q <= '0;
              c_q <= '0;
            end else begin
              i_q <= i_q + 1'b1;
            end
          end else begin
            k_q <= k_q + 1'b1;
          end
        end
        S_OUT_WAIT: out_last_q <= rc_last;
        S_OUT_HOLD: begin
          if (out_acc) begin
            if (out_last_q) begin
              r_q   <= '0;
              c_q   <= '0;
              pp_q  <= ONE_FX;
              ovf_q <= 1'b0;
            end else if (c_q == n_m1) begin
              c_q <= '0;
              r_q <= r_q + 1'b1;
            end else begin
              c_q <= c_q + 1'b1;
            end
          end
        end
        S_SING: begin
          if (out_acc) begin
            r_q   <= '0;
            c_q   <= '0;
            pp_q  <= ONE_FX;
            ovf_q <= 1'b0;
          end
        end
        default: begin
        end
      endcase
      if (cfg_we_i) begin
        size_q <= cfg_wdata_i;
        r_q    <= '0;
        c_q    <= '0;
        pp_q   <= ONE_FX;
        ovf_q  <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    prod_q <= 64'(mul_a) * 64'(mul_b);
    if (state_q == S_PIV_WAIT) begin
      piv_q <= $signed(ram_rdata);
    end
    if (state_q == S_DIV_WR) begin
      prow_q[k_q] <= div_res.val;
    end
    if (state_q == S_F_WAIT) begin
      f_q <= $signed(ram_rdata);
    end
    if (state_q == S_EL_WAIT) begin
      old_q <= $signed(ram_rdata);
    end
    if (state_q == S_OUT_WAIT) begin
      out_elem_q <= $signed(ram_rdata);
    end
  end

  // never loading and returning results at once
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && m_axis_tvalid_o))
    else $error("input and output active together");

  // a finished run always returns to loading
  a_last_to_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && m_axis_tlast_o && !cfg_we_i) |=> (state_q == S_LOAD))
    else $error("run did not return to loading");

  // the divider never sees a zero pivot
  a_piv_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> (piv_q != '0))
    else $error("division by zero pivot");

  // results are never written while being returned
  a_no_write_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !ram_we)
    else $error("store written while returning results");

  // a nonzero pivot value is followed by the determinant update
  a_piv_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PIV_WAIT && ram_rdata != '0 && !cfg_we_i) |=> (state_q == S_PIV_SAT))
    else $error("pivot sequence broken");

endmodule

@@ tb/gauss_jordan_matrix_inverse_tb.sv @@
// ----------------------------------------------------------------------------
// gauss_jordan_matrix_inverse_tb
// Streams matrices of varied sizes and content into the inverse block and
// checks every returned inverse element, determinant, status and tlast
// against a fixed-point Gauss-Jordan predictor kept in the bench.
// ----------------------------------------------------------------------------
module gauss_jordan_matrix_inverse_tb;
  import gji_pkg::*;

  localparam int unsigned MAX_N  = 8;
  localparam int unsigned FRAC   = 16;
  localparam int unsigned SETTLE = 40;
  localparam logic signed [31:0] FX_ONE = 32'sh0001_0000;

  typedef struct packed {
    logic signed [31:0] inv;
    logic signed [31:0] det;
    gji_status_e        status;
    logic               last;
  } inv_result_t;

  typedef enum logic {ROW_CFG, ROW_ELEM} row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    logic [31:0]        value;
    logic               typed;
    logic signed [31:0] inv;
    logic signed [31:0] det;
    gji_status_e        status;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [3:0]  cfg_wdata_i;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [71:0] m_axis_tdata_o;
  logic        m_axis_tlast_o;

  gauss_jordan_matrix_inverse u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  // predictor state
  logic signed [31:0] aug [MAX_N][2*MAX_N];
  int unsigned        load_cnt;
  logic signed [31:0] piv_prod;
  logic               ovf_seen;
  logic [3:0]         size_reg;

  inv_result_t inverse_q[$];
  int unsigned mismatches;
  int unsigned send_idle;
  int unsigned recv_idle;
  int unsigned items_sent;
  int unsigned big_runs;
  bit          hold_req;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic signed [31:0] sat32(longint v);
    if (v > longint'(32'sh7fff_ffff)) begin
      ovf_seen = 1'b1;
      return 32'sh7fff_ffff;
    end
    if (v < -longint'(64'sh8000_0000)) begin
      ovf_seen = 1'b1;
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  // floor of the product scaled down by the fraction bits
  function automatic longint mul_floor(logic signed [31:0] a, logic signed [31:0] b);
    longint p;
    p = longint'(a) * longint'(b);
    return p >>> FRAC;
  endfunction

  function automatic void clear_run();
    load_cnt = 0;
    piv_prod = FX_ONE;
    ovf_seen = 1'b0;
  endfunction

  function automatic int unsigned active_n();
    if (size_reg == 0) return 1;
    if (size_reg > MAX_N) return MAX_N;
    return size_reg;
  endfunction

  function automatic void invert_step(logic [31:0] elem);
    int unsigned n;
    logic signed [31:0] piv;
    logic signed [31:0] f;
    inv_result_t r;
    n = active_n();
    if (load_cnt >= n * n) load_cnt = 0;
    aug[load_cnt / n][load_cnt % n] = elem;
    load_cnt++;
    if (load_cnt < n * n) return;
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++)
        aug[i][n + j] = (i == j) ? FX_ONE : 32'sd0;
    for (int i = 0; i < n; i++) begin
      piv = aug[i][i];
      if (piv == 0) begin
        r = '{inv: 0, det: 0, status: STAT_SING, last: 1'b1};
        inverse_q.push_back(r);
        clear_run();
        return;
      end
      piv_prod = sat32(mul_floor(piv_prod, piv));
      for (int k = 0; k < 2 * n; k++)
        aug[i][k] = sat32((longint'(aug[i][k]) <<< FRAC) / longint'(piv));
      for (int j = 0; j < n; j++) begin
        if (j == i) continue;
        f = aug[j][i];
        for (int k = 0; k < 2 * n; k++)
          aug[j][k] = sat32(longint'(aug[j][k]) - mul_floor(f, aug[i][k]));
      end
    end
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++) begin
        r.inv    = aug[i][n + j];
        r.det    = piv_prod;
        r.status = ovf_seen ? STAT_SAT : STAT_OK;
        r.last   = (i == n - 1) && (j == n - 1);
        inverse_q.push_back(r);
      end
    clear_run();
  endfunction

  // block is idle only once every result is back and it has settled
  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    while (inverse_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_size(logic [3:0] v);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    size_reg = v;
    clear_run();
  endtask

  task automatic send_elem(logic [31:0] v);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= v;
    do @(posedge clk_i); while (!s_axis_tready_o);
    invert_step(v);
    items_sent++;
  endtask

  function automatic logic [31:0] small_fx();
    return $signed($urandom_range(65535)) - 32768;
  endfunction

  task automatic random_matrix();
    int unsigned n;
    int unsigned style;
    int unsigned abort_at;
    logic [3:0]  sz;
    logic [31:0] v;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 4 && big_runs < 3) begin
      sz = $urandom_range(1) ? 4'd8 : 4'd15;
      big_runs++;
    end else if (pick < 10) sz = 4'd0;
    else if (pick < 20) sz = 4'($urandom_range(5, 7));
    else sz = 4'($urandom_range(1, 4));
    write_size(sz);
    n = active_n();
    style = $urandom_range(99);
    abort_at = ($urandom_range(99) < 5) ? $urandom_range(n * n - 1) : n * n + 1;
    for (int e = 0; e < n * n; e++) begin
      if (e == abort_at && e != 0) begin
        write_size(sz);
        return;
      end
      if (style < 70) begin
        if (e / n == e % n) begin
          v = $urandom_range(FX_ONE, 8 * FX_ONE);
          if ($urandom_range(1)) v = -v;
        end else v = small_fx();
      end else if (style < 80) v = $urandom();
      else if (style < 88) begin
        case ($urandom_range(4))
          0: v = 32'h7fff_ffff;
          1: v = 32'h8000_0000;
          2: v = 32'h0000_0000;
          3: v = 32'h0000_0001;
          default: v = 32'hffff_ffff;
        endcase
      end else begin
        // zero diagonal element on row n/2
        v = (e / n == e % n && e / n == n / 2) ? 32'h0 : small_fx() + FX_ONE;
      end
      send_elem(v);
    end
  endtask

  // receiver: random stalls plus long hold-offs on request
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    m_axis_tready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 4000;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  always @(posedge clk_i) begin
    inv_result_t got;
    inv_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.inv    = m_axis_tdata_o[31:0];
      got.det    = m_axis_tdata_o[63:32];
      got.status = gji_status_e'(m_axis_tdata_o[65:64]);
      got.last   = m_axis_tlast_o;
      if (inverse_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: inv %h det %h status %0d last %0b",
                   got.inv, got.det, got.status, got.last);
      end else begin
        want = inverse_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp inv %h det %h st %0d last %0b, ",
                      "got inv %h det %h st %0d last %0b"},
                     want.inv, want.det, want.status, want.last,
                     got.inv, got.det, got.status, got.last);
        end
      end
    end
  end

  initial begin
    #(12 * 3_000_000);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    stim_row_t rows[$];
    stim_row_t row;
    inv_result_t typed_res;
    rows = '{
      '{ROW_CFG,  32'd1,          1'b0, 0, 0, STAT_OK},
      '{ROW_ELEM, 32'h0001_0000,  1'b1, 32'sh0001_0000, 32'sh0001_0000, STAT_OK},
      '{ROW_ELEM, 32'h0000_0000,  1'b1, 32'sh0, 32'sh0, STAT_SING},
      '{ROW_ELEM, 32'h7fff_ffff,  1'b1, 32'sh2, 32'sh7fff_ffff, STAT_OK},
      '{ROW_ELEM, 32'h8000_0000,  1'b1, -32'sh2, 32'sh8000_0000, STAT_OK},
      '{ROW_ELEM, 32'h0000_0001,  1'b1, 32'sh7fff_ffff, 32'sh1, STAT_SAT},
      // size zero acts as one
      '{ROW_CFG,  32'd0,          1'b0, 0, 0, STAT_OK},
      '{ROW_ELEM, 32'h0002_0000,  1'b1, 32'sh8000, 32'sh0002_0000, STAT_OK},
      // partial load dropped by a size write
      '{ROW_CFG,  32'd2,          1'b0, 0, 0, STAT_OK},
      '{ROW_ELEM, 32'hffff_ffff,  1'b0, 0, 0, STAT_OK},
      '{ROW_ELEM, 32'h1234_5678,  1'b0, 0, 0, STAT_OK},
      '{ROW_CFG,  32'd2,          1'b0, 0, 0, STAT_OK},
      '{ROW_ELEM, 32'h0001_0000,  1'b0, 0, 0, STAT_OK},
      '{ROW_ELEM, 32'h0002_0000,  1'b0, 0, 0, STAT_OK},
      '{ROW_ELEM, 32'h0003_0000,  1'b0, 0, 0, STAT_OK},
      '{ROW_ELEM, 32'h0004_0000,  1'b0, 0, 0, STAT_OK},
      // zero pivot on the second row
      '{ROW_ELEM, 32'h0001_0000,  1'b0, 0, 0, STAT_OK},
      '{ROW_ELEM, 32'h0001_0000,  1'b0, 0, 0, STAT_OK},
      '{ROW_ELEM, 32'h0001_0000,  1'b0, 0, 0, STAT_OK},
      '{ROW_ELEM, 32'h0001_0000,  1'b0, 0, 0, STAT_OK}
    };
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = 4'd0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = 32'd0;
    hold_req        = 1'b0;
    mismatches      = 0;
    items_sent      = 0;
    big_runs        = 0;
    send_idle       = 17;
    recv_idle       = 79;
    size_reg        = 4'd4;
    clear_run();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      row = rows[i];
      if (row.kind == ROW_CFG) write_size(row.value[3:0]);
      else begin
        send_elem(row.value);
        if (row.typed) begin
          typed_res = '{inv: row.inv, det: row.det, status: row.status, last: 1'b1};
          void'(inverse_q.pop_back());
          inverse_q.push_back(typed_res);
        end
      end
    end

    while (items_sent < 370) begin
      if (items_sent >= 250) begin
        send_idle = 0;
        recv_idle = 0;
      end else if (items_sent >= 140) begin
        send_idle = 79;
        recv_idle = 17;
      end
      if (items_sent >= 80 && items_sent < 100) begin
        // long receiver hold while the sender keeps offering
        write_size(4'd3);
        hold_req = 1'b1;
        for (int e = 0; e < 18; e++) send_elem(small_fx() + ((e % 4 == 0) ? FX_ONE : 0));
      end
      random_matrix();
    end

    s_axis_tvalid_i <= 1'b0;
    while (inverse_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ gauss_jordan_matrix_inverse.f @@
rtl/gji_pkg.sv
rtl/gji_ram.sv
rtl/gji_div.sv
rtl/gauss_jordan_matrix_inverse.sv
tb/gauss_jordan_matrix_inverse_tb.sv
